/* hdl/wcu_pkg.sv */
// Package for the windowed CPU utilization block: sizes, widths and constants.
// No dependencies; the top level and the divider import it.
package wcu_pkg;

  localparam int HISTORY_DEPTH      = 1024;
  localparam int CPU_SLOTS          = 16;
  localparam int STATE_COUNT        = 8;
  localparam int SAMPLES_PER_MINUTE = 60;

  localparam int POS_W  = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SLOT_W = $clog2(CPU_SLOTS);
  localparam int SIDX_W = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
  localparam int CNT_W  = 64;
  localparam int ROW_W  = STATE_COUNT * CNT_W;
  localparam int ADDR_W = SLOT_W + POS_W;
  localparam int RAM_DEPTH = CPU_SLOTS * HISTORY_DEPTH;

  localparam int SPAN_1M  = SAMPLES_PER_MINUTE;
  localparam int SPAN_5M  = 5 * SAMPLES_PER_MINUTE;
  localparam int SPAN_15M = 15 * SAMPLES_PER_MINUTE;

  // Percent in Q16: 100 * 65536
  localparam int PCT_W  = 23;
  localparam logic [PCT_W-1:0] PCT_FULL = 23'd6553600;
  localparam int PROD_W = 32 + PCT_W;
  localparam int NUM_W  = CNT_W + PCT_W;

  // Opcodes and window codes
  localparam logic [1:0] OP_REC_GOOD = 2'd0;
  localparam logic [1:0] OP_REC_FAIL = 2'd1;
  localparam logic [1:0] OP_QUERY    = 2'd2;
  localparam logic [1:0] WIN_1M      = 2'd0;
  localparam logic [1:0] WIN_5M      = 2'd1;
  localparam logic [1:0] WIN_15M     = 2'd2;
  localparam logic [1:0] WIN_BAD     = 2'd3;

  typedef logic [STATE_COUNT-1:0][CNT_W-1:0] row_t;

endpackage

/* hdl/wcu_if.sv */
// Valid/ready channel interfaces of the windowed CPU utilization block.
// Depends on nothing; payload widths follow the field list of the block.
interface wcu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  cpu_slot;
  logic [2:0]  state_sel;
  logic [1:0]  window_mode;
  logic [63:0] counter_user;
  logic [63:0] counter_nice;
  logic [63:0] counter_system;
  logic [63:0] counter_idle;
  logic [63:0] counter_iowait;
  logic [63:0] counter_interrupt;
  logic [63:0] counter_softirq;
  logic [63:0] counter_steal;
  modport source (output valid, opcode, cpu_slot, state_sel, window_mode, counter_user,
                  counter_nice, counter_system, counter_idle, counter_iowait,
                  counter_interrupt, counter_softirq, counter_steal, input ready);
  modport sink (input valid, opcode, cpu_slot, state_sel, window_mode, counter_user,
                counter_nice, counter_system, counter_idle, counter_iowait,
                counter_interrupt, counter_softirq, counter_steal, output ready);
endinterface

interface wcu_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [22:0] percent_q16;
  modport source (output valid, status, percent_q16, input ready);
  modport sink (input valid, status, percent_q16, output ready);
endinterface

interface wcu_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] cpu_count;
  modport source (output valid, cpu_count, input ready);
  modport sink (input valid, cpu_count, output ready);
endinterface

/* hdl/windowed_cpu_utilization.sv */
// Top level: ring histories per CPU slot and the query sequencer.
// Depends on wcu_pkg, wcu_if interfaces, wcu_ram and wcu_div.
//
//  channel | dir | word
//  --------+-----+-------------------------------------------------------------
//  in_w    | in  | opcode, cpu_slot, state_sel, window_mode, eight 64-bit counters
//  out_w   | out | status, percent_q16 (one word per query)
//  cfg_w   | in  | cpu_count
//
// A record is written on accept; the sequencer stays idle. A query with two usable
// entries reads the newest entry, scans past failed samples for the base entry,
// reads it, sums, compares, multiplies, adds and runs the 87-step divider; a lone
// entry skips scan and base read. A zero total or saturated share skips multiply and
// divide; a rejected query, empty history or failed newest entry skips to output.
// Reset is synchronous; ring heads and fill counts clear at once, history
// memories need no clearing. A finished query waits in the output register.
module windowed_cpu_utilization (
  input logic        clk,
  input logic        rst_n,
  wcu_in_if.sink     in_w,
  wcu_out_if.source  out_w,
  wcu_cfg_if.sink    cfg_w
);
  import wcu_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WCUR   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_WBASE  = 4'd3;
  localparam logic [3:0] S_SUM    = 4'd4;
  localparam logic [3:0] S_CMP    = 4'd5;
  localparam logic [3:0] S_MUL1   = 4'd6;
  localparam logic [3:0] S_MUL2   = 4'd7;
  localparam logic [3:0] S_ADD    = 4'd8;
  localparam logic [3:0] S_DSTART = 4'd9;
  localparam logic [3:0] S_DIV    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0]        state_r, state_nxt;
  logic [3:0]        cpu_count_r;
  logic [POS_W-1:0]  head_r [CPU_SLOTS];
  logic [FILL_W-1:0] fill_r [CPU_SLOTS];

  logic [SLOT_W-1:0] slot_r;
  logic [2:0]        sel_r;
  logic [POS_W-1:0]  base_r;
  logic              one_r;
  row_t              cur_row_r, base_row_r;
  logic [SIDX_W-1:0] idx_r;
  logic [CNT_W-1:0]  whole_r, part_r;
  logic [PROD_W-1:0] lo_r, hi_r;
  logic [NUM_W-1:0]  num_r;
  logic              stat_r;
  logic [PCT_W-1:0]  pct_r;
  logic              out_valid_r;
  logic              out_stat_r;
  logic [PCT_W-1:0]  out_pct_r;

  // accept-time decode
  logic              acc, slot_ok, is_rec, q_fail;
  logic [SLOT_W-1:0] sidx;
  logic [POS_W-1:0]  head_c;
  logic [FILL_W-1:0] fill_c, fill_m1, back_c;
  logic [FILL_W:0]   sum_c, sum_m1, base_d;
  logic [POS_W-1:0]  pos_c, cur_c, base_c, base_inc;
  logic [31:0]       span_c;
  row_t              in_row;

  // memory ports
  logic              c_we, g_we;
  logic [ADDR_W-1:0] c_raddr, g_raddr, w_addr;
  logic [ROW_W-1:0]  c_rdata;
  logic [0:0]        g_rdata;
  logic [CNT_W-1:0]  diff_c;
  logic              div_done;
  logic [PCT_W-1:0]  div_q;
  logic              out_free;

  assign acc      = in_w.valid && in_w.ready;
  assign in_w.ready = (state_r == S_IDLE);
  assign cfg_w.ready = 1'b1;
  assign out_free = !out_valid_r || out_w.ready;

  assign sidx    = SLOT_W'(in_w.cpu_slot);
  assign slot_ok = (32'(in_w.cpu_slot) < CPU_SLOTS) && (in_w.cpu_slot <= cpu_count_r);
  assign is_rec  = (in_w.opcode == OP_REC_GOOD) || (in_w.opcode == OP_REC_FAIL);
  assign head_c  = head_r[sidx];
  assign fill_c  = fill_r[sidx];

  // ring positions: write slot, newest entry, and base entry
  always_comb begin
    sum_c  = (FILL_W+1)'(head_c) + (FILL_W+1)'(fill_c);
    pos_c  = (sum_c >= (FILL_W+1)'(HISTORY_DEPTH)) ?
             POS_W'(sum_c - (FILL_W+1)'(HISTORY_DEPTH)) : POS_W'(sum_c);
    sum_m1 = sum_c - 1'b1;
    cur_c  = (sum_m1 >= (FILL_W+1)'(HISTORY_DEPTH)) ?
             POS_W'(sum_m1 - (FILL_W+1)'(HISTORY_DEPTH)) : POS_W'(sum_m1);
    fill_m1 = fill_c - 1'b1;
    unique case (in_w.window_mode)
      WIN_1M:  span_c = 32'(SPAN_1M);
      WIN_5M:  span_c = 32'(SPAN_5M);
      default: span_c = 32'(SPAN_15M);
    endcase
    back_c = (32'(fill_m1) > span_c) ? FILL_W'(span_c) : fill_m1;
    base_d = (FILL_W+1)'(cur_c) - (FILL_W+1)'(back_c);
    base_c = base_d[FILL_W] ? POS_W'(base_d + (FILL_W+1)'(HISTORY_DEPTH)) : POS_W'(base_d);
    q_fail = (32'(in_w.state_sel) >= STATE_COUNT) || (in_w.window_mode == WIN_BAD) ||
             !slot_ok;
    base_inc = (base_r == POS_W'(HISTORY_DEPTH - 1)) ? '0 : base_r + 1'b1;
  end

  always_comb begin
    in_row    = '0;
    in_row[0] = in_w.counter_user;
    if (STATE_COUNT > 1) in_row[1 % STATE_COUNT] = in_w.counter_nice;
    if (STATE_COUNT > 2) in_row[2 % STATE_COUNT] = in_w.counter_system;
    if (STATE_COUNT > 3) in_row[3 % STATE_COUNT] = in_w.counter_idle;
    if (STATE_COUNT > 4) in_row[4 % STATE_COUNT] = in_w.counter_iowait;
    if (STATE_COUNT > 5) in_row[5 % STATE_COUNT] = in_w.counter_interrupt;
    if (STATE_COUNT > 6) in_row[6 % STATE_COUNT] = in_w.counter_softirq;
    if (STATE_COUNT > 7) in_row[7 % STATE_COUNT] = in_w.counter_steal;
  end

  // memory write and read addressing
  assign g_we   = acc && is_rec && slot_ok;
  assign c_we   = g_we && (in_w.opcode == OP_REC_GOOD);
  assign w_addr = {sidx, pos_c};

  always_comb begin
    c_raddr = {sidx, cur_c};
    g_raddr = {sidx, cur_c};
    unique case (state_r)
      S_WCUR:  g_raddr = {slot_r, base_r};
      S_SCAN: begin
        c_raddr = {slot_r, base_r};
        g_raddr = {slot_r, base_inc};
      end
      default: ;
    endcase
  end

  wcu_ram #(.WIDTH(ROW_W), .DEPTH(RAM_DEPTH)) u_cnt_ram (
    .clk(clk), .we(c_we), .waddr(w_addr), .wdata(in_row),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  wcu_ram #(.WIDTH(1), .DEPTH(RAM_DEPTH)) u_good_ram (
    .clk(clk), .we(g_we), .waddr(w_addr), .wdata(in_w.opcode == OP_REC_GOOD),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  wcu_div u_div (
    .clk(clk), .rst_n(rst_n), .start(state_r == S_DSTART),
    .num(num_r), .den(whole_r), .done(div_done), .q(div_q)
  );

  assign diff_c = cur_row_r[idx_r] - base_row_r[idx_r];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && in_w.opcode == OP_QUERY) begin
          state_nxt = (q_fail || fill_c == '0) ? S_OUT : S_WCUR;
        end
      end
      S_WCUR:   state_nxt = !g_rdata[0] ? S_OUT : (one_r ? S_SUM : S_SCAN);
      S_SCAN:   if (g_rdata[0]) state_nxt = S_WBASE;
      S_WBASE:  state_nxt = S_SUM;
      S_SUM:    if (idx_r == SIDX_W'(STATE_COUNT - 1)) state_nxt = S_CMP;
      S_CMP:    state_nxt = (whole_r == '0 || part_r >= whole_r) ? S_OUT : S_MUL1;
      S_MUL1:   state_nxt = S_MUL2;
      S_MUL2:   state_nxt = S_ADD;
      S_ADD:    state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_DIV;
      S_DIV:    if (div_done) state_nxt = S_OUT;
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control state: sequencer, config, ring pointers, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cpu_count_r <= 4'd1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CPU_SLOTS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_w.valid && cfg_w.ready) cpu_count_r <= cfg_w.cpu_count;
      if (g_we) begin
        if (fill_c < FILL_W'(HISTORY_DEPTH)) begin
          fill_r[sidx] <= fill_c + 1'b1;
        end else begin
          head_r[sidx] <= (head_c == POS_W'(HISTORY_DEPTH - 1)) ? '0 : head_c + 1'b1;
        end
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_w.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        slot_r  <= sidx;
        sel_r   <= in_w.state_sel;
        base_r  <= base_c;
        one_r   <= (fill_c == FILL_W'(1));
        idx_r   <= '0;
        whole_r <= '0;
        part_r  <= '0;
        pct_r   <= '0;
        stat_r  <= q_fail;
      end
      S_WCUR: begin
        cur_row_r  <= c_rdata;
        base_row_r <= '0;
        if (!g_rdata[0]) stat_r <= 1'b1;
      end
      S_SCAN:  if (!g_rdata[0]) base_r <= base_inc;
      S_WBASE: base_row_r <= c_rdata;
      S_SUM: begin
        whole_r <= whole_r + diff_c;
        if (32'(idx_r) == 32'(sel_r)) part_r <= diff_c;
        idx_r <= idx_r + 1'b1;
      end
      S_CMP:   if (whole_r != '0 && part_r >= whole_r) pct_r <= PCT_FULL;
      S_MUL1:  lo_r <= {23'b0, part_r[31:0]} * {32'b0, PCT_FULL};
      S_MUL2:  hi_r <= {23'b0, part_r[63:32]} * {32'b0, PCT_FULL};
      S_ADD:   num_r <= {hi_r, 32'b0} + NUM_W'(lo_r);
      S_DIV:   if (div_done) pct_r <= div_q;
      S_OUT: begin
        if (out_free) begin
          out_stat_r <= stat_r;
          out_pct_r  <= stat_r ? '0 : pct_r;
        end
      end
      default: ;
    endcase
  end

  assign out_w.valid       = out_valid_r;
  assign out_w.status      = out_stat_r;
  assign out_w.percent_q16 = out_pct_r;

  // the newest-entry read is issued only on query accept
  a_wcur_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WCUR |-> $past(state_r) == S_IDLE)
    else $error("newest-entry capture without a query accept");

  // the divider only runs on a proper fraction with a nonzero total
  a_div_operands: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DSTART |-> (whole_r != '0) && (part_r < whole_r))
    else $error("divider started on bad operands");

  // a scaled quotient stays below full scale
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> div_q < PCT_FULL)
    else $error("quotient out of range");

  // a failed query reports zero percent
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stat_r |-> out_pct_r == '0)
    else $error("failed query with nonzero percent");

endmodule

/* hdl/wcu_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module wcu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/wcu_div.sv */
// Restoring divider, one quotient bit per cycle, for the percent scaling.
// Depends on wcu_pkg; the quotient is known to fit in PCT_W bits.
module wcu_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [wcu_pkg::NUM_W-1:0] num,
  input  logic [wcu_pkg::CNT_W-1:0] den,
  output logic                      done,
  output logic [wcu_pkg::PCT_W-1:0] q
);
  import wcu_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [NUM_W-1:0]  num_r;
  logic [CNT_W-1:0]  den_r;
  logic [CNT_W-1:0]  rem_r;
  logic [PCT_W-1:0]  q_r;
  logic [CNT_W:0]    shifted;
  logic              fits;

  // one bit of the dividend into the partial remainder
  assign shifted = {rem_r, num_r[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(NUM_W - 1);
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        num_r <= num_r << 1;
        rem_r <= fits ? CNT_W'(shifted - {1'b0, den_r}) : shifted[CNT_W-1:0];
        q_r   <= {q_r[PCT_W-2:0], fits};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule
